@@ design/dssb_pkg.sv @@
// Shared types, constants and helper functions for the two-stack buffer.
`default_nettype none
package dssb_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_BITS   = 32;
    localparam int MAX_RESULTS = 16;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int NM_W   = $clog2(MAX_RESULTS);

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;
    localparam logic [1:0] MODE_SEARCH = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0]         mode;
        logic               stack_sel;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] data;
        logic [5:0]         position;
        logic               found;
        logic               error;
        logic [6:0]         count;
        logic               is_empty;
        logic               is_full;
        logic               last;
    } t_out_beat;

    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_emit;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [DATA_BITS-1:0] wdata;
        logic                 re;
        logic [ADDR_W-1:0]    raddr;
    } t_ram_req;

    // Stack A sits at the bottom of the store, stack B is mirrored from the top.
    function automatic logic [ADDR_W-1:0] store_addr(input logic sel,
                                                     input logic [CNT_W-1:0] pos);
        logic [ADDR_W-1:0] p;
        p = pos[ADDR_W-1:0];
        return sel ? (ADDR_W'(DEPTH - 1) - p) : p;
    endfunction

    function automatic logic [DATA_BITS-1:0] to_word(input logic signed [31:0] v);
        return DATA_BITS'(v);
    endfunction

    function automatic logic signed [31:0] from_word(input logic [DATA_BITS-1:0] w);
        return 32'($signed(w));
    endfunction

endpackage
`default_nettype wire

@@ design/dssb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dssb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ design/dssb_ctrl.sv @@
// Sequencer: stack counters, push/pop/status handling and the serial search scan.
`default_nettype none
module dssb_ctrl
    import dssb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_beat             i_in,
    input  wire logic                 i_emit_ok,
    output t_emit                     o_emit,
    output t_ram_req                  o_ram,
    input  wire logic [DATA_BITS-1:0] i_ram_rdata
);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt_up, n_cnt_up;
    logic [CNT_W-1:0]     r_cnt_dn, n_cnt_dn;
    logic                 r_sel, n_sel;
    logic [1:0]           r_mode, n_mode;
    logic [DATA_BITS-1:0] r_key, n_key;
    logic                 r_err, n_err;
    logic [CNT_W-1:0]     r_pos, n_pos;
    logic                 r_cmp_v, n_cmp_v;
    logic [CNT_W-1:0]     r_cmp_pos, n_cmp_pos;
    logic                 r_pend, n_pend;
    logic [CNT_W-1:0]     r_pend_pos, n_pend_pos;
    logic [NM_W-1:0]      r_nmatch, n_nmatch;

    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] in_cnt;
    logic [SUM_W-1:0] cnt_sum;
    logic             full_now;
    logic             hit;
    logic             cap;
    logic             scan_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt_up <= '0;
            r_cnt_dn <= '0;
            r_cmp_v  <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_up <= n_cnt_up;
            r_cnt_dn <= n_cnt_dn;
            r_cmp_v  <= n_cmp_v;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel      <= n_sel;
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_err      <= n_err;
        r_pos      <= n_pos;
        r_cmp_pos  <= n_cmp_pos;
        r_pend_pos <= n_pend_pos;
        r_nmatch   <= n_nmatch;
    end

    assign cur_cnt  = r_sel ? r_cnt_dn : r_cnt_up;
    assign in_cnt   = i_in.stack_sel ? r_cnt_dn : r_cnt_up;
    assign cnt_sum  = SUM_W'(r_cnt_up) + SUM_W'(r_cnt_dn);
    assign full_now = (cnt_sum >= SUM_W'(DEPTH));
    assign hit      = r_cmp_v && (i_ram_rdata == r_key);
    assign cap      = hit && (r_nmatch == NM_W'(MAX_RESULTS - 1));

    always_comb begin
        n_state    = r_state;
        n_cnt_up   = r_cnt_up;
        n_cnt_dn   = r_cnt_dn;
        n_sel      = r_sel;
        n_mode     = r_mode;
        n_key      = r_key;
        n_err      = r_err;
        n_pos      = r_pos;
        n_cmp_v    = r_cmp_v;
        n_cmp_pos  = r_cmp_pos;
        n_pend     = r_pend;
        n_pend_pos = r_pend_pos;
        n_nmatch   = r_nmatch;
        scan_hold  = 1'b0;

        o_in_stall = 1'b1;
        o_ram      = '0;

        o_emit                = '0;
        o_emit.beat.count     = 7'(cur_cnt);
        o_emit.beat.is_empty  = (cur_cnt == '0);
        o_emit.beat.is_full   = full_now;
        o_emit.beat.last      = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_sel  = i_in.stack_sel;
                    n_mode = i_in.mode;
                    n_key  = to_word(i_in.value);
                    n_err  = 1'b0;
                    n_state = S_EMIT;
                    unique case (i_in.mode)
                        MODE_PUSH: begin
                            n_err = full_now;
                            if (!full_now) begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = store_addr(i_in.stack_sel, in_cnt);
                                o_ram.wdata = to_word(i_in.value);
                                if (i_in.stack_sel) begin
                                    n_cnt_dn = in_cnt + CNT_W'(1);
                                end else begin
                                    n_cnt_up = in_cnt + CNT_W'(1);
                                end
                            end
                        end
                        MODE_POP: begin
                            n_err = (in_cnt == '0);
                            if (in_cnt != '0) begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = store_addr(i_in.stack_sel,
                                                         in_cnt - CNT_W'(1));
                                if (i_in.stack_sel) begin
                                    n_cnt_dn = in_cnt - CNT_W'(1);
                                end else begin
                                    n_cnt_up = in_cnt - CNT_W'(1);
                                end
                            end
                        end
                        MODE_STATUS: begin
                            n_err = 1'b0;
                        end
                        MODE_SEARCH: begin
                            n_pos    = in_cnt;
                            n_pend   = 1'b0;
                            n_nmatch = '0;
                            n_cmp_v  = 1'b0;
                            n_state  = S_SCAN;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                o_emit.valid      = 1'b1;
                o_emit.beat.error = r_err;
                if (r_mode == MODE_POP && !r_err) begin
                    o_emit.beat.data = from_word(i_ram_rdata);
                end
                if (i_emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // A new match pushes the previous one out with last clear; the
                // newest match stays pending until we know whether more follow.
                o_emit.valid         = hit && r_pend;
                o_emit.beat.found    = 1'b1;
                o_emit.beat.position = 6'(r_pend_pos);
                o_emit.beat.last     = 1'b0;
                scan_hold            = hit && r_pend && !i_emit_ok;
                if (!scan_hold) begin
                    if (hit) begin
                        n_pend     = 1'b1;
                        n_pend_pos = r_cmp_pos;
                        if (!cap) begin
                            n_nmatch = r_nmatch + NM_W'(1);
                        end
                    end
                    if (cap || r_pos == '0) begin
                        n_cmp_v = 1'b0;
                        n_state = S_FLUSH;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = store_addr(r_sel, r_pos - CNT_W'(1));
                        n_pos       = r_pos - CNT_W'(1);
                        n_cmp_pos   = r_pos - CNT_W'(1);
                        n_cmp_v     = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                o_emit.valid = 1'b1;
                if (r_pend) begin
                    o_emit.beat.found    = 1'b1;
                    o_emit.beat.position = 6'(r_pend_pos);
                end
                if (i_emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_sum <= SUM_W'(DEPTH))
        else $error("stack counts exceed the store depth");

    a_cnt_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_cnt_up != $past(r_cnt_up) || r_cnt_dn != $past(r_cnt_dn)))
        |-> $past(i_in_valid && r_state == S_IDLE))
        else $error("stack count changed without an accepted beat");

    a_scan_emit_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !r_pend) |-> !o_emit.valid)
        else $error("search emitted a beat with no pending match");

    a_scan_read_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && o_ram.re) |-> r_pos != '0)
        else $error("search read past the stack bottom");
`endif

endmodule
`default_nettype wire

@@ design/dual_stack_shared_buffer_unit.sv @@
// Top level: two stacks sharing one store, with a registered result port.
//
//  Channel  Direction  Handshake               Beat type
//  in       input      i_in_valid/o_in_stall   t_in_beat
//  out      output     o_out_valid/i_out_stall t_out_beat
//
// Push, pop and status first update the counters and touch the store, then hand
// the result to the output register.
// A search reads one stored element per cycle, unless a stall on the output holds it,
// through the single RAM read port and compares it once the registered read data returns.
// A stall on the output holds the sequencer at the next result it must send.
// Reset clears both stack counts; the store contents are not cleared.
`default_nettype none
module dual_stack_shared_buffer_unit
    import dssb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out
);

    t_emit                emit;
    t_ram_req             ram_req;
    logic [DATA_BITS-1:0] ram_rdata;
    logic                 emit_ok;

    logic      r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;

    dssb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_emit_ok   (emit_ok),
        .o_emit      (emit),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    dssb_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // The output register takes a new beat whenever it is empty or being drained.
    assign emit_ok = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (emit.valid && emit_ok) begin
            n_out       = emit.beat;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the two-stack shared buffer: directed table, then random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dssb_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 56;

    typedef struct packed {
        logic [1:0]  mode;
        logic        sel;
        logic [31:0] value;
        logic [4:0]  reps;
        logic        typed;
        logic [31:0] e_data;
        logic        e_err;
        logic [6:0]  e_count;
        logic        e_empty;
        logic        e_full;
    } t_dir_row;

    // Rows with typed results carry their expected beat; the others use the predictor.
    localparam t_dir_row DIR_ROWS [13] = '{
        '{MODE_STATUS, 1'b0, 32'h0000_0000, 5'd1,  1'b1, 32'h0, 1'b0, 7'd0,  1'b1, 1'b0},
        '{MODE_STATUS, 1'b1, 32'h0000_0000, 5'd1,  1'b1, 32'h0, 1'b0, 7'd0,  1'b1, 1'b0},
        '{MODE_POP,    1'b0, 32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0, 1'b1, 7'd0,  1'b1, 1'b0},
        '{MODE_POP,    1'b1, 32'h0000_0000, 5'd1,  1'b1, 32'h0, 1'b1, 7'd0,  1'b1, 1'b0},
        '{MODE_SEARCH, 1'b1, 32'h0000_0000, 5'd1,  1'b1, 32'h0, 1'b0, 7'd0,  1'b1, 1'b0},
        '{MODE_PUSH,   1'b0, 32'h7FFF_FFFF, 5'd16, 1'b0, 32'h0, 1'b0, 7'd0,  1'b0, 1'b0},
        '{MODE_PUSH,   1'b1, 32'h8000_0000, 5'd1,  1'b1, 32'h0, 1'b1, 7'd0,  1'b1, 1'b1},
        '{MODE_SEARCH, 1'b0, 32'h7FFF_FFFF, 5'd1,  1'b0, 32'h0, 1'b0, 7'd0,  1'b0, 1'b0},
        '{MODE_STATUS, 1'b0, 32'h0000_0000, 5'd1,  1'b1, 32'h0, 1'b0, 7'd16, 1'b0, 1'b1},
        '{MODE_POP,    1'b0, 32'h0000_0000, 5'd1,  1'b1, 32'h7FFF_FFFF, 1'b0, 7'd15, 1'b0, 1'b0},
        '{MODE_PUSH,   1'b1, 32'h8000_0000, 5'd1,  1'b1, 32'h0, 1'b0, 7'd1,  1'b0, 1'b1},
        '{MODE_POP,    1'b1, 32'h0000_0000, 5'd1,  1'b1, 32'h8000_0000, 1'b0, 7'd0, 1'b1, 1'b0},
        '{MODE_SEARCH, 1'b0, 32'h8000_0000, 5'd1,  1'b0, 32'h0, 1'b0, 7'd0,  1'b0, 1'b0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out;

    // Predictor state.
    logic [DATA_BITS-1:0] store_words [DEPTH];
    int cnt_a;
    int cnt_b;

    t_out_beat due_results [$];
    t_out_beat op_results [$];
    int        errors = 0;
    bit        idle_on = 1'b1;
    int        stall_left = 0;
    int        idle_cycles = 0;
    logic [31:0] value_pool [4];

    dual_stack_shared_buffer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] word_addr(input bit sel, input int pos);
        return ADDR_W'(sel ? DEPTH - 1 - pos : pos);
    endfunction

    // Flags always reflect the counts after the operation has been applied.
    function automatic t_out_beat make_result(input logic [31:0] data, input int pos,
                                              input bit found, input bit err,
                                              input int cnt, input bit last);
        t_out_beat r;
        r.data     = data;
        r.position = 6'(pos);
        r.found    = found;
        r.error    = err;
        r.count    = 7'(cnt);
        r.is_empty = (cnt == 0);
        r.is_full  = (cnt_a + cnt_b >= DEPTH);
        r.last     = last;
        return r;
    endfunction

    task automatic apply_stack_op(input t_in_beat b);
        logic [DATA_BITS-1:0] word;
        t_out_beat tail;
        int cnt;
        int hits;
        op_results.delete();
        word = DATA_BITS'(b.value);
        cnt  = b.stack_sel ? cnt_b : cnt_a;
        case (b.mode)
            MODE_PUSH: begin
                if (cnt_a + cnt_b >= DEPTH) begin
                    op_results.push_back(make_result('0, 0, 1'b0, 1'b1, cnt, 1'b1));
                end else begin
                    store_words[word_addr(b.stack_sel, cnt)] = word;
                    cnt++;
                    if (b.stack_sel) cnt_b = cnt; else cnt_a = cnt;
                    op_results.push_back(make_result('0, 0, 1'b0, 1'b0, cnt, 1'b1));
                end
            end
            MODE_POP: begin
                if (cnt == 0) begin
                    op_results.push_back(make_result('0, 0, 1'b0, 1'b1, 0, 1'b1));
                end else begin
                    cnt--;
                    if (b.stack_sel) cnt_b = cnt; else cnt_a = cnt;
                    op_results.push_back(make_result(
                        32'($signed(store_words[word_addr(b.stack_sel, cnt)])),
                        0, 1'b0, 1'b0, cnt, 1'b1));
                end
            end
            MODE_STATUS: begin
                op_results.push_back(make_result('0, 0, 1'b0, 1'b0, cnt, 1'b1));
            end
            MODE_SEARCH: begin
                hits = 0;
                // Walk from the top of the stack down, capped at the result limit.
                for (int p = cnt - 1; p >= 0 && hits < MAX_RESULTS; p--) begin
                    if (store_words[word_addr(b.stack_sel, p)] == word) begin
                        op_results.push_back(make_result('0, p, 1'b1, 1'b0, cnt, 1'b0));
                        hits++;
                    end
                end
                if (hits == 0) begin
                    op_results.push_back(make_result('0, 0, 1'b0, 1'b0, cnt, 1'b1));
                end else begin
                    tail = op_results.pop_back();
                    tail.last = 1'b1;
                    op_results.push_back(tail);
                end
            end
        endcase
    endtask

    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        apply_stack_op(b);
        if (typed) begin
            due_results.push_back(want);
        end else begin
            foreach (op_results[k]) due_results.push_back(op_results[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    initial begin : stimulus
        t_in_beat  b;
        t_out_beat want;
        int push_pct;
        int cnt;
        int r;
        cnt_a = 0;
        cnt_b = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[k]) begin
            b.mode      = DIR_ROWS[k].mode;
            b.stack_sel = DIR_ROWS[k].sel;
            b.value     = DIR_ROWS[k].value;
            want          = '0;
            want.data     = DIR_ROWS[k].e_data;
            want.error    = DIR_ROWS[k].e_err;
            want.count    = DIR_ROWS[k].e_count;
            want.is_empty = DIR_ROWS[k].e_empty;
            want.is_full  = DIR_ROWS[k].e_full;
            want.last     = 1'b1;
            repeat (DIR_ROWS[k].reps) send_beat(b, DIR_ROWS[k].typed, want);
        end

        // Push share falls over even phases and rises over odd ones so both full and empty are hit often.
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on  = (ph % 3) != 2;
            push_pct = (ph % 2 == 0) ? 75 - 5 * ph : 25 + 3 * ph;
            value_pool[0] = $urandom;
            value_pool[1] = $urandom;
            value_pool[2] = 32'h8000_0000;
            value_pool[3] = 32'h7FFF_FFFF;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                b.stack_sel = 1'($urandom_range(0, 1));
                r = $urandom_range(0, 99);
                if (r < push_pct) begin
                    b.mode = MODE_PUSH;
                end else begin
                    r = $urandom_range(0, 99);
                    b.mode = (r < 45) ? MODE_POP : (r < 60) ? MODE_STATUS : MODE_SEARCH;
                end
                b.value = ($urandom_range(0, 99) < 70) ? value_pool[2'($urandom_range(0, 3))]
                                                       : $urandom;
                cnt = b.stack_sel ? cnt_b : cnt_a;
                if (b.mode == MODE_SEARCH && cnt > 0 && $urandom_range(0, 1) == 1) begin
                    b.value = store_words[word_addr(b.stack_sel, $urandom_range(0, cnt - 1))];
                end
                send_beat(b, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    always @(posedge i_clk) begin : stall_gen
        int n;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            n = pick_gap();
            i_out_stall <= (n > 0);
            stall_left  <= (n > 0) ? n - 1 : 0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing expected: %h", o_out);
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("data",     want.data,              o_out.data);
                check_field("position", 32'(want.position),     32'(o_out.position));
                check_field("found",    32'(want.found),        32'(o_out.found));
                check_field("error",    32'(want.error),        32'(o_out.error));
                check_field("count",    32'(want.count),        32'(o_out.count));
                check_field("is_empty", 32'(want.is_empty),     32'(o_out.is_empty));
                check_field("is_full",  32'(want.is_full),      32'(o_out.is_full));
                check_field("last",     32'(want.last),         32'(o_out.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
